>>> src/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants for the two-cluster k-means block.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int COORD_W   = 16;
  localparam int ITER_W    = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_BITS = 32;
  localparam int WIDX_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED0    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED1    = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      last_point;
  } kmc_in_t;

  typedef struct packed {
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] label_bits;
    logic                 converged;
    logic                 overflow;
    logic                 last_word;
  } kmc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED0,
    ST_SEED1,
    ST_SEED2,
    ST_PASS,
    ST_DIV_ISSUE,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_OUT_READ,
    ST_OUT_FLUSH,
    ST_EMIT
  } kmc_state_t;

endpackage

>>> src/kmc_div.sv
// ----------------------------------------------------------------------------
// kmc_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module kmc_div #(
  parameter int DW = 27,
  parameter int VW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] num,
  input  logic [VW-1:0]        den,
  output logic                 done,
  output logic signed [DW-1:0] quo
);
  localparam int STW = $clog2(DW + 1);

  logic          run;
  logic [STW-1:0] step;
  logic [DW-1:0] mag;
  logic [VW-1:0] rem;
  logic          neg;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, mag[DW-1]};
  assign fits  = trial >= {1'b0, den};
  assign quo   = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= run && (step == STW'(1));
      if (start) begin
        run  <= 1'b1;
        step <= STW'(DW);
      end else if (run) begin
        step <= step - STW'(1);
        if (step == STW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[DW-1];
      mag <= num[DW-1] ? DW'(-num) : DW'(num);
      rem <= '0;
    end else if (run) begin
      rem <= fits ? VW'(trial - {1'b0, den}) : trial[VW-1:0];
      mag <= {mag[DW-2:0], fits};
    end
  end

endmodule

>>> src/two_cluster_kmeans.sv
// ----------------------------------------------------------------------------
// two_cluster_kmeans
// Loads 2-D points into a memory, then runs two-cluster k-means over them and
// returns the labels packed 32 to a word.
// ----------------------------------------------------------------------------
// channel  | handshake                | payload
// point    | start / busy             | coord_x, coord_y, last_point
// result   | result_valid (one cycle) | word_index, label_bits, converged,
//          |                          | overflow, last_word
// config   | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// points load one per cycle; busy stays low while a set is loading
// after the last point: seeding, then per pass the points run through the
// point memory read pipeline and the four centroid sums through the divider
// label output reads each word's labels through the one-bit label memory port
// rst is synchronous; results cannot be stalled and show for one cycle each
module two_cluster_kmeans #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  kmc_pkg::kmc_in_t                 point,
  output logic                             result_valid,
  output kmc_pkg::kmc_out_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmc_pkg::CFG_W-1:0]        cfg_data
);
  import kmc_pkg::*;

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int OW   = $clog2(MAX_POINTS + WORD_BITS);
  localparam int SW   = (CW > CFG_W) ? CW : CFG_W;
  localparam int PW   = 2 * COORD_W;
  localparam int DW   = COORD_W + 1;
  localparam int SQW  = 2 * DW;
  localparam int DSW  = SQW + 1;
  localparam int SUMW = COORD_W + CW;
  localparam int BW   = $clog2(WORD_BITS);

  kmc_state_t state, state_next;

  // configuration
  logic [ITER_W-1:0] max_iter;
  logic [CFG_W-1:0]  seed0, seed1;

  // storage
  logic [PW-1:0] pmem [MAX_POINTS];
  logic          lmem [MAX_POINTS];
  logic [PW-1:0] pm_q;
  logic          lm_q;
  logic [AW-1:0] pm_addr, lm_addr;
  logic          pm_we;

  logic [CW-1:0] cnt;
  logic          ovf;
  logic signed [COORD_W-1:0] c0x, c0y, c1x, c1y;

  // pass pipeline
  logic [CW-1:0]     iss;
  logic [ITER_W-1:0] iter, lim;
  logic              v1, v2, v3;
  logic [AW-1:0]     idx1, idx2, idx3;
  logic              lab2, lab3;
  logic signed [COORD_W-1:0] p2x, p2y, p3x, p3y;
  logic [DW-1:0]     a0x, a0y, a1x, a1y;
  logic [SQW-1:0]    q0x, q0y, q1x, q1y;
  logic [DSW-1:0]    d0, d1;
  logic              lab_new;
  logic              changed;
  logic signed [SUMW-1:0] sum0x, sum0y, sum1x, sum1y;
  logic [CW-1:0]     cnt0, cnt1;
  logic signed [COORD_W-1:0] rx, ry;

  // centroid update
  logic [1:0]             sel;
  logic                   div_start, div_done;
  logic signed [SUMW-1:0] div_num, div_quo;
  logic [CW-1:0]          div_den;

  // label output
  logic [OW-1:0]        oi;
  logic [WIDX_W-1:0]    wi;
  logic [WORD_BITS-1:0] obits;
  logic                 capv, capin;
  logic [BW-1:0]        capk;
  logic                 conv;

  logic [SW-1:0] n_ext, s0_ext, s1_ext, s0c, s1c;
  logic          pass_end, out_last;

  function automatic logic [DW-1:0] absdiff(logic signed [COORD_W-1:0] a,
                                             logic signed [COORD_W-1:0] b);
    logic signed [DW-1:0] e;
    e = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return e[DW-1] ? DW'(-e) : DW'(e);
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign lim       = (max_iter == '0) ? ITER_W'(1) : max_iter;

  assign n_ext  = SW'(cnt);
  assign s0_ext = SW'(seed0);
  assign s1_ext = SW'(seed1);
  assign s0c    = (s0_ext >= n_ext) ? n_ext - SW'(1) : s0_ext;
  assign s1c    = (s1_ext >= n_ext) ? n_ext - SW'(1) : s1_ext;

  assign pm_we    = (state == ST_IDLE) && start && (cnt < CW'(MAX_POINTS));
  assign pass_end = (iss == cnt) && !v1 && !v2 && !v3;
  assign out_last = (oi >= OW'(cnt));

  assign rx = $signed(pm_q[PW-1:COORD_W]);
  assign ry = $signed(pm_q[COORD_W-1:0]);

  assign d0      = DSW'(q0x) + DSW'(q0y);
  assign d1      = DSW'(q1x) + DSW'(q1y);
  assign lab_new = d1 < d0;

  always_comb begin
    case (sel)
      2'd0:    div_num = sum0x;
      2'd1:    div_num = sum0y;
      2'd2:    div_num = sum1x;
      default: div_num = sum1y;
    endcase
  end
  assign div_den = sel[1] ? cnt1 : cnt0;

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pm_addr    = iss[AW-1:0];
    lm_addr    = iss[AW-1:0];
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start && point.last_point) begin
          state_next = ST_SEED0;
        end
      end
      ST_SEED0: begin
        pm_addr    = s0c[AW-1:0];
        state_next = ST_SEED1;
      end
      ST_SEED1: begin
        pm_addr    = s1c[AW-1:0];
        state_next = ST_SEED2;
      end
      ST_SEED2: begin
        state_next = ST_PASS;
      end
      ST_PASS: begin
        if (pass_end) begin
          state_next = ST_DIV_ISSUE;
        end
      end
      ST_DIV_ISSUE: begin
        if (div_den != '0) begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end else if (sel == 2'd3) begin
          state_next = ST_CHECK;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (sel == 2'd3) ? ST_CHECK : ST_DIV_ISSUE;
        end
      end
      ST_CHECK: begin
        if (!changed || iter == lim) begin
          state_next = ST_OUT_READ;
        end else begin
          state_next = ST_PASS;
        end
      end
      ST_OUT_READ: begin
        lm_addr = oi[AW-1:0];
        if (oi[BW-1:0] == BW'(WORD_BITS - 1)) begin
          state_next = ST_OUT_FLUSH;
        end
      end
      ST_OUT_FLUSH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        state_next = out_last ? ST_IDLE : ST_OUT_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= ITER_W'(32);
      seed0    <= CFG_W'(0);
      seed1    <= CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_ITER: max_iter <= cfg_data[ITER_W-1:0];
        CFG_SEED0:    seed0    <= cfg_data;
        CFG_SEED1:    seed1    <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[cnt[AW-1:0]] <= {point.coord_x, point.coord_y};
    end
    pm_q <= pmem[pm_addr];
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      lmem[idx3] <= lab_new;
    end
    lm_q <= lmem[lm_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      ovf          <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      capv         <= 1'b0;
      result_valid <= 1'b0;
      iss          <= '0;
      iter         <= '0;
      sel          <= '0;
      oi           <= '0;
      wi           <= '0;
      changed      <= 1'b0;
      conv         <= 1'b0;
    end else begin
      result_valid <= (state == ST_EMIT);
      v1           <= (state == ST_PASS) && (iss != cnt);
      v2           <= v1;
      v3           <= v2;
      capv         <= (state == ST_OUT_READ);
      if (state == ST_IDLE && start) begin
        if (pm_we) begin
          cnt <= cnt + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == ST_PASS && iss != cnt) begin
        iss <= iss + CW'(1);
      end
      if (v3 && iter != ITER_W'(1) && lab_new != lab3) begin
        changed <= 1'b1;
      end
      unique case (state)
        ST_SEED2: begin
          iss     <= '0;
          iter    <= ITER_W'(1);
          changed <= 1'b1;
          sel     <= '0;
        end
        ST_DIV_ISSUE: begin
          if (div_den == '0) begin
            sel <= sel + 2'd1;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            sel <= sel + 2'd1;
          end
        end
        ST_CHECK: begin
          if (!changed || iter == lim) begin
            conv <= !changed;
            oi   <= '0;
            wi   <= '0;
          end else begin
            iter    <= iter + ITER_W'(1);
            iss     <= '0;
            changed <= 1'b0;
          end
        end
        ST_OUT_READ: begin
          oi <= oi + OW'(1);
        end
        ST_EMIT: begin
          wi <= wi + WIDX_W'(1);
          if (out_last) begin
            cnt <= '0;
            ovf <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    idx1 <= iss[AW-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    lab2 <= lm_q;
    lab3 <= lab2;
    p2x  <= rx;
    p2y  <= ry;
    p3x  <= p2x;
    p3y  <= p2y;
    a0x  <= absdiff(rx, c0x);
    a0y  <= absdiff(ry, c0y);
    a1x  <= absdiff(rx, c1x);
    a1y  <= absdiff(ry, c1y);
    q0x  <= a0x * a0x;
    q0y  <= a0y * a0y;
    q1x  <= a1x * a1x;
    q1y  <= a1y * a1y;

    if (state == ST_SEED1) begin
      c0x <= rx;
      c0y <= ry;
    end
    if (state == ST_SEED2) begin
      c1x <= rx;
      c1y <= ry;
    end
    if (state == ST_DIV_WAIT && div_done) begin
      case (sel)
        2'd0:    c0x <= div_quo[COORD_W-1:0];
        2'd1:    c0y <= div_quo[COORD_W-1:0];
        2'd2:    c1x <= div_quo[COORD_W-1:0];
        default: c1y <= div_quo[COORD_W-1:0];
      endcase
    end

    if (state == ST_SEED2 || state == ST_CHECK) begin
      sum0x <= '0;
      sum0y <= '0;
      sum1x <= '0;
      sum1y <= '0;
      cnt0  <= '0;
      cnt1  <= '0;
    end else if (v3) begin
      if (lab_new) begin
        sum1x <= sum1x + SUMW'(p3x);
        sum1y <= sum1y + SUMW'(p3y);
        cnt1  <= cnt1 + CW'(1);
      end else begin
        sum0x <= sum0x + SUMW'(p3x);
        sum0y <= sum0y + SUMW'(p3y);
        cnt0  <= cnt0 + CW'(1);
      end
    end

    // label bits land in the cycle after their read
    capk  <= oi[BW-1:0];
    capin <= (oi < OW'(cnt));
    if (state == ST_CHECK) begin
      obits <= '0;
    end else if (state == ST_EMIT) begin
      obits <= '0;
    end else if (capv) begin
      obits[capk] <= capin & lm_q;
    end

    if (state == ST_EMIT) begin
      result.word_index <= wi;
      result.label_bits <= obits;
      result.converged  <= conv;
      result.overflow   <= ovf;
      result.last_word  <= out_last;
    end
  end

  kmc_div #(
    .DW(SUMW),
    .VW(CW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

`ifndef SYNTH
  a_word_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_EMIT))
    else $error("result word without emit");

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!v1 && !v2 && !v3))
    else $error("pass pipeline busy while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside wait");
`endif

endmodule
